### sv/assert_macros.svh
// assertion macros used by the receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define XCR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define XCR_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define XCR_ASSERT(label, clk, rst_n, prop, msg)
`define XCR_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

### sv/xcr_pkg.sv
// types, codes and crc step for the xmodem crc receiver
package xcr_pkg;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [1:0] KIND_TX   = 2'd0;
  localparam logic [1:0] KIND_FIN  = 2'd1;
  localparam logic [1:0] KIND_RD   = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_TIMEOUT = 2'd1;
  localparam logic [1:0] STAT_CANCEL  = 2'd2;
  localparam logic [1:0] STAT_BIG     = 2'd3;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_PAD = 8'h1a;
  localparam logic [7:0] B_REQ = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [3:0] P_IDLE  = 4'd0;
  localparam logic [3:0] P_SHAKE = 4'd1;
  localparam logic [3:0] P_NUM   = 4'd2;
  localparam logic [3:0] P_COMP  = 4'd3;
  localparam logic [3:0] P_DATA  = 4'd4;
  localparam logic [3:0] P_CRCH  = 4'd5;
  localparam logic [3:0] P_CRCL  = 4'd6;
  localparam logic [3:0] P_HEAD  = 4'd7;
  localparam logic [3:0] P_FLUSH = 4'd8;

  localparam logic [10:0] LEN_SHORT = 11'd128;
  localparam logic [10:0] LEN_LONG  = 11'd1024;

  localparam logic [2:0] REG_TRIES = 3'd0;
  localparam logic [2:0] REG_SHAKE = 3'd1;
  localparam logic [2:0] REG_BYTE  = 3'd2;
  localparam logic [2:0] REG_HEAD  = 3'd3;
  localparam logic [2:0] REG_QUIET = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] len;
  } res_t;

  function automatic res_t mk_res(logic [1:0] kind, logic [7:0] data,
                                  logic [1:0] status, logic [15:0] len);
    res_t r;
    r.kind = kind;
    r.data = data;
    r.status = status;
    r.len = len;
    return r;
  endfunction

  // crc-16/xmodem, msb first, one byte
  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### sv/xcr_ram.sv
// generic single-port-write, registered-read ram
module xcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### sv/xmodem_crc_receiver.sv
// xmodem-crc receiver: framing, crc check, replies and staging memory
//
// channel | dir | tuser        | tdata / other
// in_     | in  | command      | rx_byte, read_address
// out_    | out | out_kind     | out_byte, status, file_length; tlast = last
// cfg_    | in  | -            | cfg_we, cfg_index, cfg_wdata
//
// one beat at a time: a byte, tick or start is handled in its accept cycle,
// a read waits in S_RD for the registered staging ram port, results then go out
// one per cycle while out_tready is high. the trailing pad trim after eot reads
// the ram backward, alternating S_TRIM and S_TCHK, over at most the last block.
// reset is synchronous; out_tready low just holds the pending results.
module xmodem_crc_receiver #(
  parameter int STAGING_BYTES = 32768
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rx_byte[7:0], read_address[22:8]
  input  logic [1:0]  in_tuser,   // command[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_byte[7:0], status[9:8], file_length[25:10]
  output logic [1:0]  out_tuser,  // out_kind[1:0]
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);
  import xcr_pkg::*;

  localparam int AW = $clog2(STAGING_BYTES);
  localparam int TW = $clog2(STAGING_BYTES + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_TRIM = 3'd2;
  localparam logic [2:0] S_TCHK = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [7:0]  tries_cfg_r;
  logic [15:0] shake_cfg_r, byte_cfg_r, head_cfg_r, quiet_cfg_r;

  logic [2:0]  st_r, st_nxt;
  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  tries_r, tries_nxt;
  logic [7:0]  expn_r, expn_nxt;
  logic [TW-1:0] total_r, total_nxt;
  logic [10:0] lastlen_r, lastlen_nxt;
  logic [10:0] blen_r, blen_nxt;
  logic [10:0] bidx_r, bidx_nxt;
  logic [7:0]  gnum_r, gnum_nxt;
  logic [7:0]  gcomp_r, gcomp_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] crcrx_r, crcrx_nxt;
  logic        bad_r, bad_nxt;
  logic [1:0]  pend_r, pend_nxt;

  res_t        res_r [2];
  res_t        res_nxt [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        idx_r;
  logic        trim_go;
  logic [TW-1:0] len_r, floor_r;
  logic        oor_r;

  logic [7:0]  rx_byte;
  logic [14:0] rd_address;
  logic [1:0]  cmd;
  logic        acc;
  logic        mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]  mem_rdata;
  logic [TW:0] wsum;
  logic [TW:0] fit_sum;
  logic [15:0] limit, timer_inc;
  logic        blk_ok;
  logic [8:0]  nsum;

  assign rx_byte    = in_tdata[7:0];
  assign rd_address = in_tdata[22:8];
  assign cmd        = in_tuser;
  assign in_tready  = (st_r == S_IDLE);
  assign acc        = in_tvalid && in_tready;

  assign wsum    = (TW+1)'(total_r) + (TW+1)'(bidx_r);
  assign fit_sum = (TW+1)'(total_r) + (TW+1)'(blen_r);
  assign nsum    = {1'b0, gnum_r} + {1'b0, gcomp_r};
  assign blk_ok  = !bad_r && (nsum == 9'd255) && (crcrx_r == crc_r);
  assign timer_inc = (timer_r == 16'hffff) ? timer_r : timer_r + 16'd1;

  always_comb begin
    if (phase_r == P_SHAKE) limit = shake_cfg_r;
    else if (phase_r == P_HEAD) limit = head_cfg_r;
    else if (phase_r == P_FLUSH) limit = quiet_cfg_r;
    else limit = byte_cfg_r;
  end

  assign mem_we    = acc && (cmd == CMD_BYTE) && (phase_r == P_DATA) &&
                     (32'(wsum) < STAGING_BYTES);
  assign mem_waddr = AW'(wsum);
  assign mem_raddr = (st_r == S_TRIM) ? AW'(len_r - TW'(1)) : AW'(rd_address);

  xcr_ram #(.WIDTH(8), .DEPTH(STAGING_BYTES)) u_stage (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (rx_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // one beat of the protocol engine
  always_comb begin
    phase_nxt = phase_r;   timer_nxt = timer_r;   tries_nxt = tries_r;
    expn_nxt = expn_r;     total_nxt = total_r;   lastlen_nxt = lastlen_r;
    blen_nxt = blen_r;     bidx_nxt = bidx_r;     gnum_nxt = gnum_r;
    gcomp_nxt = gcomp_r;   crc_nxt = crc_r;       crcrx_nxt = crcrx_r;
    bad_nxt = bad_r;       pend_nxt = pend_r;
    res_nxt[0] = res_r[0]; res_nxt[1] = res_r[1];
    cnt_nxt = 2'd0;
    trim_go = 1'b0;
    unique case (cmd)
      CMD_START: begin
        timer_nxt = '0; expn_nxt = 8'd1; total_nxt = '0;
        lastlen_nxt = LEN_SHORT; blen_nxt = LEN_SHORT; bidx_nxt = '0;
        gnum_nxt = '0; gcomp_nxt = '0; crc_nxt = '0; crcrx_nxt = '0;
        bad_nxt = 1'b0; pend_nxt = STAT_OK;
        if (tries_cfg_r == 8'd0) begin
          tries_nxt = '0;
          res_nxt[0] = mk_res(KIND_FIN, 8'h00, STAT_TIMEOUT, 16'd0);
          cnt_nxt = 2'd1;
          phase_nxt = P_IDLE;
        end else begin
          tries_nxt = 8'd1;
          res_nxt[0] = mk_res(KIND_TX, B_REQ, STAT_OK, 16'd0);
          cnt_nxt = 2'd1;
          phase_nxt = P_SHAKE;
        end
      end
      CMD_BYTE: begin
        unique case (phase_r)
          P_SHAKE, P_HEAD: begin
            if (rx_byte == B_SOH || rx_byte == B_STX) begin
              blen_nxt = (rx_byte == B_SOH) ? LEN_SHORT : LEN_LONG;
              bidx_nxt = '0; crc_nxt = '0; crcrx_nxt = '0; bad_nxt = 1'b0;
              gnum_nxt = '0; gcomp_nxt = '0;
              phase_nxt = P_NUM; timer_nxt = '0;
            end else if (rx_byte == B_EOT) begin
              res_nxt[0] = mk_res(KIND_TX, B_ACK, STAT_OK, 16'd0);
              res_nxt[1] = mk_res(KIND_FIN, 8'h00, STAT_OK, 16'd0);
              cnt_nxt = 2'd2;
              trim_go = 1'b1;
              phase_nxt = P_IDLE; timer_nxt = '0;
            end else if (rx_byte == B_CAN) begin
              pend_nxt = STAT_CANCEL; phase_nxt = P_FLUSH; timer_nxt = '0;
            end else if (phase_r == P_HEAD) begin
              res_nxt[0] = mk_res(KIND_TX, B_NAK, STAT_OK, 16'd0);
              cnt_nxt = 2'd1;
              timer_nxt = '0;
            end else if (tries_r >= tries_cfg_r) begin
              res_nxt[0] = mk_res(KIND_FIN, 8'h00, STAT_TIMEOUT, 16'd0);
              cnt_nxt = 2'd1;
              phase_nxt = P_IDLE; timer_nxt = '0;
            end else begin
              res_nxt[0] = mk_res(KIND_TX, B_REQ, STAT_OK, 16'd0);
              cnt_nxt = 2'd1;
              if (tries_r != 8'hff) tries_nxt = tries_r + 8'd1;
              timer_nxt = '0;
            end
          end
          P_NUM: begin
            gnum_nxt = rx_byte; phase_nxt = P_COMP; timer_nxt = '0;
          end
          P_COMP: begin
            gcomp_nxt = rx_byte; phase_nxt = P_DATA; timer_nxt = '0;
          end
          P_DATA: begin
            crc_nxt = crc_step(crc_r, rx_byte);
            bidx_nxt = bidx_r + 11'd1;
            if (bidx_r + 11'd1 >= blen_r) phase_nxt = P_CRCH;
            timer_nxt = '0;
          end
          P_CRCH: begin
            crcrx_nxt = {rx_byte, 8'h00}; phase_nxt = P_CRCL; timer_nxt = '0;
          end
          P_CRCL: begin
            // end of block with the low crc byte in
            if (!bad_r && (nsum == 9'd255) && ({crcrx_r[15:8], rx_byte} == crc_r)) begin
              if (gnum_r == expn_r && 32'(fit_sum) > STAGING_BYTES) begin
                res_nxt[0] = mk_res(KIND_TX, B_CAN, STAT_OK, 16'd0);
                res_nxt[1] = mk_res(KIND_TX, B_CAN, STAT_OK, 16'd0);
                cnt_nxt = 2'd2;
                pend_nxt = STAT_BIG; phase_nxt = P_FLUSH; timer_nxt = '0;
              end else begin
                if (gnum_r == expn_r) begin
                  total_nxt = TW'(fit_sum);
                  lastlen_nxt = blen_r;
                  expn_nxt = expn_r + 8'd1;
                end
                res_nxt[0] = mk_res(KIND_TX, B_ACK, STAT_OK, 16'd0);
                cnt_nxt = 2'd1;
                phase_nxt = P_HEAD; timer_nxt = '0;
              end
            end else begin
              res_nxt[0] = mk_res(KIND_TX, B_NAK, STAT_OK, 16'd0);
              cnt_nxt = 2'd1;
              phase_nxt = P_HEAD; timer_nxt = '0;
            end
            crcrx_nxt = {crcrx_r[15:8], rx_byte};
          end
          P_FLUSH: timer_nxt = '0;
          default: ;
        endcase
      end
      CMD_TICK: begin
        if (phase_r != P_IDLE) begin
          timer_nxt = timer_inc;
          if (timer_inc >= limit) begin
            unique case (phase_r)
              P_SHAKE: begin
                if (tries_r >= tries_cfg_r) begin
                  res_nxt[0] = mk_res(KIND_FIN, 8'h00, STAT_TIMEOUT, 16'd0);
                  cnt_nxt = 2'd1;
                  phase_nxt = P_IDLE;
                end else begin
                  res_nxt[0] = mk_res(KIND_TX, B_REQ, STAT_OK, 16'd0);
                  cnt_nxt = 2'd1;
                  if (tries_r != 8'hff) tries_nxt = tries_r + 8'd1;
                end
                timer_nxt = '0;
              end
              P_HEAD, P_FLUSH: begin
                res_nxt[0] = mk_res(KIND_FIN, 8'h00,
                                    (phase_r == P_HEAD) ? STAT_TIMEOUT : pend_r, 16'd0);
                cnt_nxt = 2'd1;
                phase_nxt = P_IDLE; timer_nxt = '0;
              end
              P_NUM, P_COMP, P_CRCH: begin
                bad_nxt = 1'b1; timer_nxt = '0;
                phase_nxt = (phase_r == P_NUM) ? P_COMP :
                            (phase_r == P_COMP) ? P_DATA : P_CRCL;
              end
              P_DATA, P_CRCL: begin
                // a missing byte always fails the block
                bad_nxt = 1'b1;
                res_nxt[0] = mk_res(KIND_TX, B_NAK, STAT_OK, 16'd0);
                cnt_nxt = 2'd1;
                phase_nxt = P_HEAD; timer_nxt = '0;
              end
              default: ;
            endcase
          end
        end
      end
      CMD_READ: ;
      default: ;
    endcase
  end

  // sequencer: accept, read wait, trim walk, result beats
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (acc) begin
          if (cmd == CMD_READ) st_nxt = S_RD;
          else if (trim_go) st_nxt = S_TRIM;
          else if (cnt_nxt != 2'd0) st_nxt = S_OUT;
        end
      end
      S_RD: st_nxt = S_OUT;
      S_TRIM: st_nxt = (len_r > floor_r) ? S_TCHK : S_OUT;
      S_TCHK: st_nxt = (mem_rdata == B_PAD || mem_rdata == 8'h00) ? S_TRIM : S_OUT;
      S_OUT: if (out_tready && (idx_r == cnt_r[1])) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tries_cfg_r <= 8'd60;
      shake_cfg_r <= 16'd3000;
      byte_cfg_r  <= 16'd1000;
      head_cfg_r  <= 16'd3000;
      quiet_cfg_r <= 16'd200;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TRIES: tries_cfg_r <= cfg_wdata[7:0];
        REG_SHAKE: shake_cfg_r <= cfg_wdata;
        REG_BYTE:  byte_cfg_r  <= cfg_wdata;
        REG_HEAD:  head_cfg_r  <= cfg_wdata;
        REG_QUIET: quiet_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;     phase_r <= P_IDLE;  timer_r <= '0;
      tries_r <= '0;      expn_r <= 8'd1;     total_r <= '0;
      lastlen_r <= LEN_SHORT; blen_r <= LEN_SHORT; bidx_r <= '0;
      gnum_r <= '0;       gcomp_r <= '0;      crc_r <= '0;
      crcrx_r <= '0;      bad_r <= 1'b0;      pend_r <= STAT_OK;
      cnt_r <= '0;        idx_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (acc) begin
        phase_r <= phase_nxt;   timer_r <= timer_nxt;   tries_r <= tries_nxt;
        expn_r <= expn_nxt;     total_r <= total_nxt;   lastlen_r <= lastlen_nxt;
        blen_r <= blen_nxt;     bidx_r <= bidx_nxt;     gnum_r <= gnum_nxt;
        gcomp_r <= gcomp_nxt;   crc_r <= crc_nxt;       crcrx_r <= crcrx_nxt;
        bad_r <= bad_nxt;       pend_r <= pend_nxt;
        cnt_r <= (cmd == CMD_READ) ? 2'd1 : cnt_nxt;
        idx_r <= 1'b0;
      end else if (st_r == S_OUT && out_tready) begin
        idx_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r[0] <= res_nxt[0];
      res_r[1] <= res_nxt[1];
      oor_r <= (32'(rd_address) >= STAGING_BYTES);
      len_r <= total_r;
      floor_r <= (total_r >= TW'(lastlen_r)) ? total_r - TW'(lastlen_r) : '0;
    end else if (st_r == S_RD) begin
      res_r[0] <= mk_res(KIND_RD, oor_r ? 8'h00 : mem_rdata, STAT_OK, 16'd0);
    end else if (st_r == S_TCHK) begin
      if (mem_rdata == B_PAD || mem_rdata == 8'h00) len_r <= len_r - TW'(1);
      else res_r[1].len <= 16'(len_r);
    end else if (st_r == S_TRIM && !(len_r > floor_r)) begin
      res_r[1].len <= 16'(len_r);
    end
  end

  assign out_tvalid = (st_r == S_OUT);
  assign out_tuser  = res_r[idx_r].kind;
  assign out_tdata  = {6'd0, res_r[idx_r].len, res_r[idx_r].status, res_r[idx_r].data};
  assign out_tlast  = (idx_r == cnt_r[1]);

  `include "assert_macros.svh"

  `XCR_ASSERT(a_trim_floor, clk, rst_n, (st_r == S_TRIM) |-> (len_r >= floor_r), "trim below floor")
  `XCR_ASSERT(a_out_cnt, clk, rst_n, out_tvalid |-> (cnt_r != 2'd0), "result beat with empty buffer")
  `XCR_ASSERT(a_wr_phase, clk, rst_n, mem_we |-> (phase_r == P_DATA), "staging write outside data")
  `XCR_ASSERT(a_done, clk, rst_n, (out_tvalid && out_tready && out_tlast) |=> (st_r == S_IDLE), "no return to idle after last beat")

endmodule

### tb/xmodem_crc_receiver_tb.sv
// testbench for the xmodem crc receiver: directed and random transfers checked against a predictor
`timescale 1ns / 1ps

module xmodem_crc_receiver_tb;
  import xcr_pkg::*;

  localparam int MEM_BYTES = 32768;
  localparam int IDLE_LIMIT = 20000;

  // block flaws injected by the sender
  localparam int F_NONE = 0;
  localparam int F_DUP = 1;
  localparam int F_CRC = 2;
  localparam int F_COMP = 3;
  localparam int F_CUT = 4;
  localparam int F_NUMGAP = 5;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] len;
    logic        last;
  } reply_t;

  class reply_scoreboard;
    bit [7:0]  tries_lim;
    bit [15:0] shake_ms, byte_ms, head_ms, quiet_ms;
    bit [3:0]  phase;
    bit [15:0] timer;
    bit [7:0]  tries_used, expected_number, got_num, got_comp;
    int        stored_total, last_len, blk_len, idx;
    bit [15:0] crc_run, crc_rx;
    bit        blk_bad;
    bit [1:0]  held_status;
    bit [7:0]  mem [MEM_BYTES];
    bit        written [MEM_BYTES];
    int        wr_list[$];
    reply_t    due_beats[$];
    reply_t    batch[$];
    int        errors;

    function new();
      tries_lim = 60; shake_ms = 3000; byte_ms = 1000; head_ms = 3000; quiet_ms = 200;
      phase = P_IDLE; timer = 0; tries_used = 0; expected_number = 1;
      stored_total = 0; last_len = 128; blk_len = 128; idx = 0;
      got_num = 0; got_comp = 0; crc_run = 0; crc_rx = 0; blk_bad = 0;
      held_status = 0; errors = 0;
    endfunction

    static function bit [15:0] crc16_upd(bit [15:0] c, bit [7:0] d);
      c ^= {d, 8'h00};
      for (int i = 0; i < 8; i++) c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
      return c;
    endfunction

    function void configure(bit [2:0] index, bit [15:0] v);
      case (index)
        REG_TRIES: tries_lim = v[7:0];
        REG_SHAKE: shake_ms = v;
        REG_BYTE:  byte_ms = v;
        REG_HEAD:  head_ms = v;
        REG_QUIET: quiet_ms = v;
        default: ;
      endcase
    endfunction

    function void push(logic [1:0] k, logic [7:0] d, logic [1:0] s, logic [15:0] l);
      reply_t r;
      r.kind = k; r.data = d; r.status = s; r.len = l; r.last = 0;
      if (batch.size() < 2) batch.push_back(r);
    endfunction

    function void done(bit [1:0] st);
      int lo, n;
      n = 0;
      if (st == STAT_OK) begin
        lo = stored_total >= last_len ? stored_total - last_len : 0;
        n = stored_total;
        while (n > lo && n <= MEM_BYTES && (mem[n-1] == B_PAD || mem[n-1] == 8'h00)) n--;
      end
      push(KIND_FIN, 8'h00, st, n[15:0]);
      phase = P_IDLE;
      timer = 0;
    endfunction

    function void to_flush(bit [1:0] st);
      held_status = st; phase = P_FLUSH; timer = 0;
    endfunction

    function void open_block(int n);
      blk_len = n; idx = 0; crc_run = 0; crc_rx = 0; blk_bad = 0;
      got_num = 0; got_comp = 0; phase = P_NUM; timer = 0;
    endfunction

    function bit header(bit [7:0] b);
      if (b == B_SOH) begin open_block(128); return 1; end
      if (b == B_STX) begin open_block(1024); return 1; end
      if (b == B_EOT) begin push(KIND_TX, B_ACK, 0, 0); done(STAT_OK); return 1; end
      if (b == B_CAN) begin to_flush(STAT_CANCEL); return 1; end
      return 0;
    endfunction

    function void close_block();
      if (blk_bad || (int'(got_num) + int'(got_comp) != 255) || crc_rx != crc_run) begin
        push(KIND_TX, B_NAK, 0, 0);
      end else begin
        if (got_num == expected_number) begin
          if (stored_total + blk_len > MEM_BYTES) begin
            push(KIND_TX, B_CAN, 0, 0);
            push(KIND_TX, B_CAN, 0, 0);
            to_flush(STAT_BIG);
            return;
          end
          stored_total += blk_len;
          last_len = blk_len;
          expected_number++;
        end
        push(KIND_TX, B_ACK, 0, 0);
      end
      phase = P_HEAD;
      timer = 0;
    endfunction

    function void try_over();
      if (tries_used >= tries_lim) begin done(STAT_TIMEOUT); return; end
      push(KIND_TX, B_REQ, 0, 0);
      if (tries_used < 255) tries_used++;
      timer = 0;
    endfunction

    function void on_rx(bit [7:0] b);
      int a;
      case (phase)
        P_SHAKE: if (!header(b)) try_over();
        P_HEAD: if (!header(b)) begin push(KIND_TX, B_NAK, 0, 0); timer = 0; end
        P_NUM: begin got_num = b; phase = P_COMP; timer = 0; end
        P_COMP: begin got_comp = b; phase = P_DATA; timer = 0; end
        P_DATA: begin
          a = stored_total + idx;
          if (a < MEM_BYTES) begin
            mem[a] = b;
            if (!written[a]) begin written[a] = 1; wr_list.push_back(a); end
          end
          crc_run = crc16_upd(crc_run, b);
          idx++;
          if (idx >= blk_len) phase = P_CRCH;
          timer = 0;
        end
        P_CRCH: begin crc_rx = {b, 8'h00}; phase = P_CRCL; timer = 0; end
        P_CRCL: begin crc_rx[7:0] = b; close_block(); end
        P_FLUSH: timer = 0;
        default: ;
      endcase
    endfunction

    function void on_tick();
      bit [15:0] lim;
      if (phase == P_IDLE) return;
      if (phase == P_SHAKE) lim = shake_ms;
      else if (phase == P_HEAD) lim = head_ms;
      else if (phase == P_FLUSH) lim = quiet_ms;
      else lim = byte_ms;
      if (lim == 0) lim = 1;
      if (timer != 16'hffff) timer++;
      if (timer < lim) return;
      case (phase)
        P_SHAKE: try_over();
        P_HEAD:  done(STAT_TIMEOUT);
        P_FLUSH: done(held_status);
        P_NUM:   begin blk_bad = 1; phase = P_COMP; timer = 0; end
        P_COMP:  begin blk_bad = 1; phase = P_DATA; timer = 0; end
        P_DATA:  begin blk_bad = 1; close_block(); end
        P_CRCH:  begin blk_bad = 1; phase = P_CRCL; timer = 0; end
        P_CRCL:  begin blk_bad = 1; close_block(); end
        default: ;
      endcase
    endfunction

    function void on_start();
      timer = 0; tries_used = 0; expected_number = 1; stored_total = 0;
      last_len = 128; blk_len = 128; idx = 0; got_num = 0; got_comp = 0;
      crc_run = 0; crc_rx = 0; blk_bad = 0; held_status = 0;
      if (tries_lim == 0) begin done(STAT_TIMEOUT); return; end
      push(KIND_TX, B_REQ, 0, 0);
      tries_used = 1;
      phase = P_SHAKE;
    endfunction

    function void note_item(logic [1:0] cmd, logic [7:0] b, logic [14:0] a);
      batch.delete();
      case (cmd)
        CMD_START: on_start();
        CMD_BYTE:  on_rx(b);
        CMD_TICK:  on_tick();
        default:   push(KIND_RD, mem[a], 0, 0);
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1;
      foreach (batch[i]) due_beats.push_back(batch[i]);
    endfunction

    function void check(reply_t got);
      reply_t w;
      if (due_beats.size() == 0) begin
        $error("unexpected result beat kind %0d data %h", got.kind, got.data);
        errors++;
        return;
      end
      w = due_beats.pop_front();
      if (got.kind !== w.kind) begin
        $error("out_kind expected %0d actual %0d", w.kind, got.kind); errors++;
      end
      if (got.data !== w.data) begin
        $error("out_byte expected %h actual %h", w.data, got.data); errors++;
      end
      if (got.status !== w.status) begin
        $error("status expected %0d actual %0d", w.status, got.status); errors++;
      end
      if (got.len !== w.len) begin
        $error("file_length expected %0d actual %0d", w.len, got.len); errors++;
      end
      if (got.last !== w.last) begin
        $error("last expected %0d actual %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // rx_byte[7:0], read_address[22:8]
  logic [1:0]  in_tuser = '0;   // command[1:0]
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [31:0] out_tdata;       // out_byte[7:0], status[9:8], file_length[25:10]
  logic [1:0]  out_tuser;       // out_kind[1:0]
  logic        out_tlast;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  reply_scoreboard sb = new();
  int n_items = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  int stall_roll;

  xmodem_crc_receiver u_top (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    reply_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.data = out_tdata[7:0];
      got.status = out_tdata[9:8];
      got.len = out_tdata[25:10];
      got.last = out_tlast;
      sb.check(got);
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 0;
    end else begin
      out_tready <= 1;
      stall_roll = $urandom_range(99);
      if (stall_roll < 6) stall_left = $urandom_range(3, 1);
      else if (stall_roll == 6) stall_left = $urandom_range(60, 10);
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  task automatic send(logic [1:0] cmd, logic [7:0] b, logic [14:0] a);
    int gap;
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {1'b0, a, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(cmd, b, a);
    n_items++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic rx(logic [7:0] b);
    send(CMD_BYTE, b, 15'($urandom));
  endtask

  task automatic ticks(int n);
    repeat (n) send(CMD_TICK, 8'($urandom), 15'($urandom));
  endtask

  task automatic read_back();
    if (sb.wr_list.size() > 0)
      send(CMD_READ, 8'($urandom),
           15'(sb.wr_list[$urandom_range(sb.wr_list.size() - 1)]));
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == B_SOH || b == B_STX || b == B_EOT || b == B_CAN);
    return b;
  endfunction

  // waits out every pending reply plus slack for items with no reply
  task automatic wait_idle(int slack);
    in_tvalid <= 0;
    @(posedge clk);
    while (sb.due_beats.size() > 0) @(posedge clk);
    repeat (slack) @(posedge clk);
  endtask

  task automatic set_regs(bit [7:0] tr, bit [15:0] sh, bit [15:0] by, bit [15:0] hd,
                          bit [15:0] qt);
    bit [15:0] v [5];
    v = '{{8'h00, tr}, sh, by, hd, qt};
    wait_idle(30);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_index <= i[2:0];
      cfg_wdata <= v[i];
      @(posedge clk);
      sb.configure(i[2:0], v[i]);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_block(bit long_blk, int flaw);
    int len, pads;
    logic [7:0] num, d;
    logic [15:0] crc;
    len = long_blk ? 1024 : 128;
    num = (flaw == F_DUP) ? sb.expected_number - 8'd1 : sb.expected_number;
    crc = 0;
    rx(long_blk ? B_STX : B_SOH);
    if (flaw == F_NUMGAP) ticks(sb.byte_ms);
    else rx(num);
    rx(flaw == F_COMP ? ~num ^ 8'h01 : ~num);
    pads = ($urandom_range(2) == 0) ? $urandom_range(20) : 0;
    for (int i = 0; i < len; i++) begin
      if (flaw == F_CUT && i == len / 2) begin
        ticks(sb.byte_ms);
        return;
      end
      d = (i >= len - pads) ? ($urandom_range(1) ? B_PAD : 8'h00) : 8'($urandom);
      crc = reply_scoreboard::crc16_upd(crc, d);
      rx(d);
      if ($urandom_range(99) < 2) ticks(1);
      if ($urandom_range(99) < 2) read_back();
    end
    if (flaw == F_CRC) crc ^= 16'h1 << $urandom_range(15);
    rx(crc[15:8]);
    rx(crc[7:0]);
  endtask

  task automatic transfer();
    int nb, r, flaw;
    bit quick;
    send(CMD_START, 8'($urandom), 15'($urandom));
    if ($urandom_range(4) == 0) rx(noise_byte());
    quick = sb.byte_ms <= 50;
    nb = $urandom_range(2, 1);
    for (int k = 0; k < nb; k++) begin
      if ($urandom_range(9) == 0) rx(noise_byte());
      r = $urandom_range(99);
      flaw = r < 70 ? F_NONE : r < 76 ? F_DUP : r < 84 ? F_CRC : r < 90 ? F_COMP :
             r < 95 ? F_CUT : F_NUMGAP;
      if (!quick && (flaw == F_CUT || flaw == F_NUMGAP)) flaw = F_NONE;
      send_block($urandom_range(19) == 0, flaw);
      if ($urandom_range(2) == 0) repeat ($urandom_range(3, 1)) read_back();
    end
    r = $urandom_range(99);
    if (r < 65) begin
      rx(B_EOT);
    end else if (r < 80) begin
      rx(B_CAN);
      repeat ($urandom_range(3)) rx(8'($urandom));
      if (sb.quiet_ms <= 200) ticks(sb.quiet_ms);
    end else if (r < 90) begin
      if (sb.head_ms <= 200) ticks(sb.head_ms);
    end
    // otherwise the next start abandons the transfer
  endtask

  initial begin
    bit [15:0] plan [5][5];
    int mark;
    plan = '{'{3, 4, 3, 5, 2}, '{1, 1, 1, 1, 1}, '{255, 2, 65535, 65535, 65535},
             '{5, 65535, 6, 3, 4}, '{2, 3, 2, 2, 3}};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: idle inputs, handshake retries, cancel drain, restart, empty eot
    set_regs(2, 3, 3, 3, 2);
    ticks(1);
    rx(B_SOH);
    send(CMD_START, 8'hff, 15'h7fff);
    ticks(3);
    rx(8'h55);
    send(CMD_START, 8'h00, 15'h0000);
    rx(B_CAN);
    rx(8'hff);
    ticks(2);
    send(CMD_START, 8'h00, 15'h0000);
    send(CMD_START, 8'h00, 15'h0000);
    rx(B_EOT);
    send(CMD_START, 8'h00, 15'h0000);
    ticks(3);
    ticks(3);

    for (int p = 0; p < 5; p++) begin
      set_regs(plan[p][0][7:0], plan[p][1], plan[p][2], plan[p][3], plan[p][4]);
      mark = n_items;
      while (n_items < mark + 130) transfer();
    end

    wait_idle(2200);
    if (sb.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
